// ----- design/srg_pkg.sv -----
// shared types and constants of the two-axis step ramp generator
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package srg_pkg;

  localparam int STEP_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int FRAC_W   = 8;
  localparam int E_W      = STEP_W + FRAC_W;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 8'd64;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // register index of ramp_fraction (byte address bit 2)
  localparam logic REG_RAMP_FRACTION = 1'b0;

  typedef struct packed {
    logic              cmd;
    logic [STEP_W-1:0] steps_x;
    logic [STEP_W-1:0] steps_y;
    logic              dir_x;
    logic              dir_y;
    logic              use_x;
    logic              use_y;
    logic [PERIOD_W-1:0] base_period;
  } srg_in_t;

  typedef struct packed {
    logic step_x;
    logic step_y;
    logic dir_x_out;
    logic dir_y_out;
    logic drivers_on;
    logic busy_res;
    logic done_res;
  } srg_out_t;

  // period request and response between sequencer and period unit
  typedef struct packed {
    logic              go;
    logic [STEP_W-1:0] index;
  } srg_per_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] half;
  } srg_per_rsp_t;

endpackage

// ----- design/two_axis_step_ramp_generator.sv -----
// top level of the two-axis step ramp generator: move latch, pulse phase
// sequencer and output register; depends on srg_pkg, srg_cfg_regs, srg_period_unit
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_stall / in_data): a start beat latches a move
//   (step counts, directions, axis enables, cruise period); each tick beat is
//   one microsecond of the move. every input beat yields exactly one output beat
//   (out_valid / out_stall / out_data) with the step levels of that tick.
//   apb port: ramp_fraction at byte address 0, Q0.8, reset value 64.
// output timing
//   the output beat appears in the cycle after its input beat is accepted.
//   a tick inside a pulse phase leaves the input ready for the next beat. a
//   start beat that begins a move and a tick that enters the next step index
//   stall the input until the serial divider has formed the step period,
//   one base bit at a time.
// reset
//   synchronous, active low; the block comes up idle with all move state zero.
// stall
//   a result waiting under out_stall holds in the output register; one more
//   input beat is taken only once that result leaves.

module two_axis_step_ramp_generator
  import srg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  srg_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output srg_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // sequencer states
  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  // pulse phases
  localparam logic [1:0] PH_XH = 2'd0;
  localparam logic [1:0] PH_XL = 2'd1;
  localparam logic [1:0] PH_YH = 2'd2;
  localparam logic [1:0] PH_YL = 2'd3;

  logic [FRAC_W-1:0] ramp_fraction;

  // latched move
  logic [STEP_W-1:0]   stx_r, stx_nxt;
  logic [STEP_W-1:0]   sty_r, sty_nxt;
  logic                dirx_r, dirx_nxt;
  logic                diry_r, diry_nxt;
  logic                usex_r, usex_nxt;
  logic                usey_r, usey_nxt;
  logic [PERIOD_W-1:0] base_r, base_nxt;

  // move progress
  logic [1:0]          st_r, st_nxt;
  logic [STEP_W-1:0]   total_r, total_nxt;
  logic [E_W-1:0]      e_r, e_nxt;
  logic [STEP_W-1:0]   idx_r, idx_nxt;
  logic [PERIOD_W-1:0] half_r, half_nxt;
  logic [PERIOD_W-1:0] tl_r, tl_nxt;
  logic [1:0]          ph_r, ph_nxt;
  logic                act_r, act_nxt;
  logic                go_r, go_nxt;

  // output register
  logic                out_vld_r, out_vld_nxt;
  srg_out_t            out_r, out_nxt;

  srg_per_req_t        preq;
  srg_per_rsp_t        prsp;

  logic                acc;
  logic [STEP_W-1:0]   nv;
  logic [PERIOD_W-1:0] tl_dec;
  logic [PERIOD_W-1:0] reload;
  logic                busy;
  logic                done;
  logic                sx;
  logic                sy;

  srg_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ramp_fraction(ramp_fraction)
  );

  assign preq.go    = go_r;
  assign preq.index = idx_r;

  srg_period_unit u_period (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (preq),
    .total   (total_r),
    .ramp_len(e_r),
    .base    (base_r),
    .rsp     (prsp)
  );

  // one beat in flight: wait for the period and for the output slot
  assign in_stall = (st_r != ST_READY) || (out_vld_r && out_stall);
  assign acc      = in_valid && !in_stall;

  assign nv     = idx_r + STEP_W'(1);
  assign tl_dec = tl_r - PERIOD_W'(1);
  // a half period of zero still lasts one tick
  assign reload = (half_r != '0) ? half_r : PERIOD_W'(1);

  always_comb begin
    stx_nxt     = stx_r;
    sty_nxt     = sty_r;
    dirx_nxt    = dirx_r;
    diry_nxt    = diry_r;
    usex_nxt    = usex_r;
    usey_nxt    = usey_r;
    base_nxt    = base_r;
    st_nxt      = st_r;
    total_nxt   = total_r;
    e_nxt       = e_r;
    idx_nxt     = idx_r;
    half_nxt    = half_r;
    tl_nxt      = tl_r;
    ph_nxt      = ph_r;
    act_nxt     = act_r;
    go_nxt      = 1'b0;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    busy        = 1'b0;
    done        = 1'b0;
    sx          = 1'b0;
    sy          = 1'b0;

    // ramp length in Q.8 once the move is latched
    if (st_r == ST_MUL) begin
      e_nxt  = E_W'({{FRAC_W{1'b0}}, total_r} * {{STEP_W{1'b0}}, ramp_fraction});
      go_nxt = 1'b1;
      st_nxt = ST_WAIT;
    end

    // new step period in place
    if ((st_r == ST_WAIT) && prsp.done) begin
      half_nxt = prsp.half;
      tl_nxt   = (prsp.half != '0) ? prsp.half : PERIOD_W'(1);
      st_nxt   = ST_READY;
    end

    if (acc) begin
      if (in_data.cmd == CMD_START) begin
        if (!act_r) begin
          stx_nxt   = in_data.steps_x;
          sty_nxt   = in_data.steps_y;
          dirx_nxt  = in_data.dir_x;
          diry_nxt  = in_data.dir_y;
          usex_nxt  = in_data.use_x;
          usey_nxt  = in_data.use_y;
          base_nxt  = in_data.base_period;
          total_nxt = (in_data.steps_x > in_data.steps_y) ? in_data.steps_x
                                                          : in_data.steps_y;
          // an empty move is latched but starts nothing
          if ((in_data.use_x && (in_data.steps_x != '0)) ||
              (in_data.use_y && (in_data.steps_y != '0))) begin
            act_nxt = 1'b1;
            idx_nxt = '0;
            ph_nxt  = (in_data.use_x && (in_data.steps_x != '0)) ? PH_XH : PH_YH;
            st_nxt  = ST_MUL;
          end
        end
        busy = act_nxt;
        sx   = act_nxt && (ph_nxt == PH_XH);
        sy   = act_nxt && (ph_nxt == PH_YH);
      end else begin
        busy = act_r;
        if (act_r) begin
          sx = (ph_r == PH_XH);
          sy = (ph_r == PH_YH);
          if (tl_dec != '0) begin
            tl_nxt = tl_dec;
          end else if ((ph_r == PH_XH) || (ph_r == PH_YH)) begin
            ph_nxt = ph_r + 2'd1;
            tl_nxt = reload;
          end else if ((ph_r == PH_XL) && usey_r && (idx_r < sty_r)) begin
            ph_nxt = PH_YH;
            tl_nxt = reload;
          end else if ((usex_r && (nv < stx_r)) || (usey_r && (nv < sty_r))) begin
            // next step index: period goes through the divider
            idx_nxt = nv;
            ph_nxt  = (usex_r && (nv < stx_r)) ? PH_XH : PH_YH;
            go_nxt  = 1'b1;
            st_nxt  = ST_WAIT;
          end else begin
            act_nxt = 1'b0;
            done    = 1'b1;
          end
        end
      end
      out_nxt.step_x     = sx;
      out_nxt.step_y     = sy;
      out_nxt.dir_x_out  = dirx_nxt;
      out_nxt.dir_y_out  = diry_nxt;
      out_nxt.drivers_on = busy;
      out_nxt.busy_res   = busy;
      out_nxt.done_res   = done;
      out_vld_nxt        = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stx_r     <= '0;
      sty_r     <= '0;
      dirx_r    <= 1'b0;
      diry_r    <= 1'b0;
      usex_r    <= 1'b0;
      usey_r    <= 1'b0;
      base_r    <= '0;
      st_r      <= ST_READY;
      total_r   <= '0;
      e_r       <= '0;
      idx_r     <= '0;
      half_r    <= '0;
      tl_r      <= '0;
      ph_r      <= PH_XH;
      act_r     <= 1'b0;
      go_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stx_r     <= stx_nxt;
      sty_r     <= sty_nxt;
      dirx_r    <= dirx_nxt;
      diry_r    <= diry_nxt;
      usex_r    <= usex_nxt;
      usey_r    <= usey_nxt;
      base_r    <= base_nxt;
      st_r      <= st_nxt;
      total_r   <= total_nxt;
      e_r       <= e_nxt;
      idx_r     <= idx_nxt;
      half_r    <= half_nxt;
      tl_r      <= tl_nxt;
      ph_r      <= ph_nxt;
      act_r     <= act_nxt;
      go_r      <= go_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // the divider answers only while the sequencer waits for it
  a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    prsp.done |-> (st_r == ST_WAIT))
    else $error("period response outside wait state");

  // period work only happens inside a move
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !act_r |-> (st_r == ST_READY))
    else $error("sequencer busy without an active move");

  // a running phase never sits at a zero tick count
  a_tick_left: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_READY) && act_r) |-> (tl_r != '0))
    else $error("zero tick count in a running phase");

  // the ending tick still reports busy
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.done_res) |-> (out_r.busy_res && !act_r))
    else $error("done without busy or with a move still active");
`endif

endmodule

// ----- design/srg_cfg_regs.sv -----
// apb-style configuration register: ramp_fraction
// depends on srg_pkg
`timescale 1ns / 1ps

module srg_cfg_regs
  import srg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [FRAC_W-1:0] ramp_fraction
);

  logic [FRAC_W-1:0] frac_r;
  logic [FRAC_W-1:0] frac_nxt;
  logic              hit;

  assign hit = (paddr[2] == REG_RAMP_FRACTION);

  always_comb begin
    frac_nxt = frac_r;
    if (psel && penable && pwrite && hit) begin
      frac_nxt = pwdata[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RESET;
    end else begin
      frac_r <= frac_nxt;
    end
  end

  assign prdata        = hit ? {{(APB_DW-FRAC_W){1'b0}}, frac_r} : '0;
  assign pready        = 1'b1;
  assign ramp_fraction = frac_r;

endmodule

// ----- design/srg_period_unit.sv -----
// step period unit: picks the ramp region, forms x*base/ramp bit by bit
// (x: index or index+ramp-total) by shift and subtract; depends on srg_pkg
`timescale 1ns / 1ps

module srg_period_unit
  import srg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  srg_per_req_t        req,
  input  logic [STEP_W-1:0]   total,
  input  logic [E_W-1:0]      ramp_len,
  input  logic [PERIOD_W-1:0] base,
  output srg_per_rsp_t        rsp
);

  localparam logic [1:0] PS_IDLE = 2'd0;
  localparam logic [1:0] PS_DIV  = 2'd1;
  localparam logic [1:0] PS_FIN  = 2'd2;

  localparam logic [1:0] RG_BASE  = 2'd0;
  localparam logic [1:0] RG_ACCEL = 2'd1;
  localparam logic [1:0] RG_DECEL = 2'd2;

  localparam int CNT_W = $clog2(PERIOD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PERIOD_W - 1);

  logic [1:0]          st_r, st_nxt;
  logic [1:0]          rg_r, rg_nxt;
  logic [E_W-1:0]      dvd_r, dvd_nxt;
  logic [E_W:0]        rem_r, rem_nxt;
  logic [PERIOD_W-1:0] quo_r, quo_nxt;
  logic [PERIOD_W-1:0] bsh_r, bsh_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                sub_r, sub_nxt;
  logic [PERIOD_W-1:0] half_r, half_nxt;
  logic                done_r, done_nxt;

  logic [E_W-1:0]      xs;
  logic [E_W-1:0]      ts;
  logic [E_W+1:0]      dsum;
  logic [E_W:0]        shl;
  logic [E_W:0]        acc;
  logic [PERIOD_W:0]   per;

  assign xs   = {req.index, {FRAC_W{1'b0}}};
  assign ts   = {total, {FRAC_W{1'b0}}};
  // index + ramp - total, sign bit tells the cruise region
  assign dsum = {2'b00, xs} + {2'b00, ramp_len} - {2'b00, ts};
  assign shl  = {rem_r[E_W-1:0], 1'b0};
  assign acc  = rem_r + {1'b0, dvd_r};

  always_comb begin
    st_nxt   = st_r;
    rg_nxt   = rg_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    bsh_nxt  = bsh_r;
    cnt_nxt  = cnt_r;
    sub_nxt  = sub_r;
    half_nxt = half_r;
    done_nxt = 1'b0;
    per      = '0;
    case (st_r)
      PS_IDLE: begin
        if (req.go) begin
          rem_nxt = '0;
          quo_nxt = '0;
          bsh_nxt = base;
          cnt_nxt = CNT_LAST;
          sub_nxt = 1'b0;
          st_nxt  = PS_DIV;
          if (ramp_len == '0) begin
            rg_nxt  = RG_BASE;
            dvd_nxt = '0;
          end else if (xs <= ramp_len) begin
            rg_nxt  = RG_ACCEL;
            dvd_nxt = xs;
          end else if (dsum[E_W+1] || (dsum == '0)) begin
            rg_nxt  = RG_BASE;
            dvd_nxt = '0;
          end else begin
            rg_nxt  = RG_DECEL;
            dvd_nxt = dsum[E_W-1:0];
          end
        end
      end
      PS_DIV: begin
        if (!sub_r) begin
          // doubling half step
          if (shl >= {1'b0, ramp_len}) begin
            rem_nxt = shl - {1'b0, ramp_len};
            quo_nxt = {quo_r[PERIOD_W-2:0], 1'b1};
          end else begin
            rem_nxt = shl;
            quo_nxt = {quo_r[PERIOD_W-2:0], 1'b0};
          end
          sub_nxt = 1'b1;
        end else begin
          // add half step for the current base bit
          if (bsh_r[PERIOD_W-1]) begin
            if (acc >= {1'b0, ramp_len}) begin
              rem_nxt = acc - {1'b0, ramp_len};
              quo_nxt = quo_r + PERIOD_W'(1);
            end else begin
              rem_nxt = acc;
            end
          end
          bsh_nxt = {bsh_r[PERIOD_W-2:0], 1'b0};
          sub_nxt = 1'b0;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            st_nxt = PS_FIN;
          end
        end
      end
      PS_FIN: begin
        case (rg_r)
          RG_ACCEL: per = {base, 1'b0} - {1'b0, quo_r}
                          - {{PERIOD_W{1'b0}}, (rem_r != '0)};
          RG_DECEL: per = {1'b0, base} + {1'b0, quo_r};
          default:  per = {1'b0, base};
        endcase
        half_nxt = per[PERIOD_W:1];
        done_nxt = 1'b1;
        st_nxt   = PS_IDLE;
      end
      default: begin
        st_nxt = PS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= PS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rg_r   <= rg_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    bsh_r  <= bsh_nxt;
    cnt_r  <= cnt_nxt;
    sub_r  <= sub_nxt;
    half_r <= half_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.half = half_r;

endmodule
